/* sv/sm3_hash_engine_macros.svh */
// Assertion macros used by the SM3 hash engine checker.
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define SM3_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sm3_hash_engine: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define SM3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sm3_hash_engine: next-cycle check failed");

`endif

/* sv/sm3_pkg.sv */
// Types, constants and helper functions for the SM3 hash engine.
package sm3_pkg;

  localparam logic [31:0] InitValue [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  localparam logic [31:0] TLow      = 32'h79cc4519;
  localparam logic [31:0] THigh     = 32'h7a879d8a;
  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [31:0] PadMarker = {PadByte, 24'h000000};

  localparam int unsigned ByteCntW = 61;

  // Source of the word shifted into the block window.
  typedef enum logic [2:0] {
    SEL_DATA   = 3'd0,
    SEL_MASKED = 3'd1,
    SEL_MARKER = 3'd2,
    SEL_ZERO   = 3'd3,
    SEL_LEN_HI = 3'd4,
    SEL_LEN_LO = 3'd5
  } push_sel_e;

  typedef struct packed {
    logic      push;
    push_sel_e sel;
    logic      add_bytes;
    logic [2:0] byte_cnt;
    logic      load_v;
    logic      round_en;
    logic [5:0] round_idx;
    logic      last_round;
    logic      restart;
    logic [2:0] out_idx;
  } dp_cmd_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

  // Byte count of a final word; codes above four count as a full word.
  function automatic logic [2:0] clamp_bytes(input logic [2:0] n);
    return (n > 3'd4) ? 3'd4 : n;
  endfunction

endpackage

/* sv/sm3_if.sv */
// Valid/ready channel interfaces for message words and digest words.
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        final_word;

  modport source (output valid, data_word, valid_bytes, final_word, input ready);
  modport sink   (input valid, data_word, valid_bytes, final_word, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

/* sv/sm3_ctrl.sv */
// Control state machine: word counting, padding sequence, rounds and digest output.
module sm3_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_final_i,
  input  logic [2:0]         in_nbytes_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         word_index_o,
  output logic               digest_last_o,
  output sm3_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PAD   = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       pad_q, pad_d;
  logic       marker_q, marker_d;
  logic       len_q, len_d;
  logic       done_q, done_d;
  logic [2:0] nb;
  logic       blk_full;

  assign nb            = sm3_pkg::clamp_bytes(in_nbytes_i);
  assign blk_full      = (cnt_q == 4'd15);
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign word_index_o  = idx_q;
  assign digest_last_o = (idx_q == 3'd7);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rnd_d    = rnd_q;
    idx_d    = idx_q;
    pad_d    = pad_q;
    marker_d = marker_q;
    len_d    = len_q;
    done_d   = done_q;
    cmd_o           = '0;
    cmd_o.sel       = sm3_pkg::SEL_ZERO;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.push      = 1'b1;
          cmd_o.add_bytes = 1'b1;
          cnt_d           = cnt_q + 4'd1;
          if (!in_final_i) begin
            cmd_o.sel      = sm3_pkg::SEL_DATA;
            cmd_o.byte_cnt = 3'd4;
          end else begin
            cmd_o.byte_cnt = nb;
            cmd_o.sel      = (nb == 3'd4) ? sm3_pkg::SEL_DATA : sm3_pkg::SEL_MASKED;
            marker_d       = (nb == 3'd4);
            pad_d          = 1'b1;
            len_d          = 1'b0;
            done_d         = 1'b0;
          end
          if (blk_full) begin
            cmd_o.load_v = 1'b1;
            state_d      = ST_ROUND;
          end else if (in_final_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.push = 1'b1;
        cnt_d      = cnt_q + 4'd1;
        // The marker of a full final word goes first, then zeros up to the length pair.
        if (marker_q) begin
          cmd_o.sel = sm3_pkg::SEL_MARKER;
          marker_d  = 1'b0;
        end else if (!len_q && cnt_q != 4'd14) begin
          cmd_o.sel = sm3_pkg::SEL_ZERO;
        end else if (!len_q) begin
          cmd_o.sel = sm3_pkg::SEL_LEN_HI;
          len_d     = 1'b1;
        end else begin
          cmd_o.sel = sm3_pkg::SEL_LEN_LO;
          done_d    = 1'b1;
        end
        if (blk_full) begin
          cmd_o.load_v = 1'b1;
          state_d      = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          cmd_o.last_round = 1'b1;
          if (!pad_q) begin
            state_d = ST_IDLE;
          end else if (done_q) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            pad_d         = 1'b0;
            done_d        = 1'b0;
            len_d         = 1'b0;
            state_d       = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      pad_q    <= 1'b0;
      marker_q <= 1'b0;
      len_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      pad_q    <= pad_d;
      marker_q <= marker_d;
      len_q    <= len_d;
      done_q   <= done_d;
    end
  end

endmodule

/* sv/sm3_dp.sv */
// Datapath: block window with on-the-fly expansion, round unit, chaining value, byte count.
module sm3_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sm3_pkg::dp_cmd_t cmd_i,
  input  logic [31:0]      data_word_i,
  input  logic [2:0]       valid_bytes_i,
  output logic [31:0]      digest_word_o
);

  logic [31:0] win_q [16];
  logic [31:0] v_q   [8];
  logic [31:0] cv_q  [8];
  logic [31:0] v_next [8];
  logic [sm3_pkg::ByteCntW-1:0] bytes_q;

  logic [31:0] push_word;
  logic [31:0] exp_word;
  logic [31:0] shift_word;
  logic [31:0] masked_word;
  logic [31:0] a12, t_rot, ss1, ss2, ff, gg, tt1, tt2;
  logic        low_rounds;

  // Final word below four bytes: keep the valid bytes and place the marker after them.
  always_comb begin
    case (sm3_pkg::clamp_bytes(valid_bytes_i))
      3'd0:    masked_word = {sm3_pkg::PadByte, 24'h000000};
      3'd1:    masked_word = {data_word_i[31:24], sm3_pkg::PadByte, 16'h0000};
      3'd2:    masked_word = {data_word_i[31:16], sm3_pkg::PadByte, 8'h00};
      3'd3:    masked_word = {data_word_i[31:8], sm3_pkg::PadByte};
      default: masked_word = data_word_i;
    endcase
  end

  always_comb begin
    case (cmd_i.sel)
      sm3_pkg::SEL_DATA:   push_word = data_word_i;
      sm3_pkg::SEL_MASKED: push_word = masked_word;
      sm3_pkg::SEL_MARKER: push_word = sm3_pkg::PadMarker;
      sm3_pkg::SEL_LEN_HI: push_word = bytes_q[60:29];
      sm3_pkg::SEL_LEN_LO: push_word = {bytes_q[28:0], 3'b000};
      default:             push_word = '0;
    endcase
  end

  // The window holds W[j..j+15]; the expanded word W[j+16] enters at the top.
  assign exp_word = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl32(win_q[13], 5'd15))
                  ^ sm3_pkg::rotl32(win_q[3], 5'd7) ^ win_q[10];
  assign shift_word = cmd_i.push ? push_word : exp_word;

  assign low_rounds = (cmd_i.round_idx[5:4] == 2'b00);
  assign a12   = sm3_pkg::rotl32(v_q[0], 5'd12);
  assign t_rot = sm3_pkg::rotl32(low_rounds ? sm3_pkg::TLow : sm3_pkg::THigh,
                                 cmd_i.round_idx[4:0]);
  assign ss1   = sm3_pkg::rotl32(a12 + v_q[4] + t_rot, 5'd7);
  assign ss2   = ss1 ^ a12;
  assign ff    = low_rounds ? (v_q[0] ^ v_q[1] ^ v_q[2])
                            : ((v_q[0] & v_q[1]) | (v_q[1] & v_q[2]) | (v_q[2] & v_q[0]));
  assign gg    = low_rounds ? (v_q[4] ^ v_q[5] ^ v_q[6])
                            : ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
  assign tt1   = ff + v_q[3] + ss2 + (win_q[0] ^ win_q[4]);
  assign tt2   = gg + v_q[7] + ss1 + win_q[0];

  always_comb begin
    v_next[0] = tt1;
    v_next[1] = v_q[0];
    v_next[2] = sm3_pkg::rotl32(v_q[1], 5'd9);
    v_next[3] = v_q[2];
    v_next[4] = sm3_pkg::perm0(tt2);
    v_next[5] = v_q[4];
    v_next[6] = sm3_pkg::rotl32(v_q[5], 5'd19);
    v_next[7] = v_q[6];
  end

  assign digest_word_o = cv_q[cmd_i.out_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= shift_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i]  <= '0;
        cv_q[i] <= sm3_pkg::InitValue[i];
      end
      bytes_q <= '0;
    end else begin
      if (cmd_i.load_v) begin
        for (int i = 0; i < 8; i++) begin
          v_q[i] <= cv_q[i];
        end
      end else if (cmd_i.round_en) begin
        for (int i = 0; i < 8; i++) begin
          v_q[i] <= v_next[i];
        end
      end
      if (cmd_i.round_en && cmd_i.last_round) begin
        for (int i = 0; i < 8; i++) begin
          cv_q[i] <= cv_q[i] ^ v_next[i];
        end
      end else if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) begin
          cv_q[i] <= sm3_pkg::InitValue[i];
        end
      end
      if (cmd_i.restart) begin
        bytes_q <= '0;
      end else if (cmd_i.add_bytes) begin
        bytes_q <= bytes_q + sm3_pkg::ByteCntW'(cmd_i.byte_cnt);
      end
    end
  end

endmodule

/* sv/sm3_hash_engine.sv */
// Top level of the SM3 hash engine: message word channel in, digest word channel out.
// Usage: message words enter on in_i, big-endian, one transfer per word. Every word
// but the last carries four bytes; the last has final_word set and valid_bytes 0..4.
// In_i is ready only while the engine waits for a word. The word that finishes a
// 16-word block starts a compression, one round per cycle in the single round unit,
// during which in_i is held off. After the final word the engine appends the padding
// words itself, one per cycle, pausing for the rounds of each block they complete;
// the trailer fills one or two blocks. Then the eight digest words leave on out_o,
// word_index 0 to 7, digest_last on the eighth, one per cycle while out_o.ready is
// high. A stalled receiver holds the current word steady; no new message word is
// taken until all eight are transferred. After the eighth transfer the chaining
// value and byte count return to their initial values and the engine takes the
// next message.
// Reset (rst_ni low, asynchronous) aborts any message in progress and leaves the
// engine ready for the first word of a new message.
module sm3_hash_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  sm3_in_if.sink          in_i,
  sm3_out_if.source       out_o
);

  sm3_pkg::dp_cmd_t cmd;
  logic             ready;
  logic             out_valid;
  logic [2:0]       word_index;
  logic             digest_last;
  logic [31:0]      digest_word;

  sm3_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_final_i    (in_i.final_word),
    .in_nbytes_i   (in_i.valid_bytes),
    .in_ready_o    (ready),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_o.ready),
    .word_index_o  (word_index),
    .digest_last_o (digest_last),
    .cmd_o         (cmd)
  );

  sm3_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_word_i   (in_i.data_word),
    .valid_bytes_i (in_i.valid_bytes),
    .digest_word_o (digest_word)
  );

  assign in_i.ready        = ready;
  assign out_o.valid       = out_valid;
  assign out_o.digest_word = digest_word;
  assign out_o.word_index  = word_index;
  assign out_o.digest_last = digest_last;

endmodule

/* sv/sm3_hash_engine_chk.sv */
// Port-level assertion checker for the SM3 hash engine and its bind statement.
`include "sm3_hash_engine_macros.svh"

module sm3_hash_engine_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] word_index_i,
  input logic       digest_last_i
);

  // Digest words and message words are never offered in the same cycle.
  `SM3_ASSERT_SAME(a_no_overlap, out_valid_i, !in_ready_i)

  `SM3_ASSERT_SAME(a_last_flag, out_valid_i, digest_last_i == (word_index_i == 3'd7))

  // Digest words leave in order without gaps in the index.
  `SM3_ASSERT_NEXT(a_index_step, out_valid_i && out_ready_i && !digest_last_i,
                   out_valid_i && (word_index_i == $past(word_index_i) + 3'd1))

  `SM3_ASSERT_NEXT(a_ready_after_digest, out_valid_i && out_ready_i && digest_last_i,
                   in_ready_i && !out_valid_i)

  `SM3_ASSERT_NEXT(a_hold_stalled, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(word_index_i))

endmodule

bind sm3_hash_engine sm3_hash_engine_chk u_sm3_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .word_index_i  (out_o.word_index),
  .digest_last_i (out_o.digest_last)
);
